// ----- sv/cnws_pkg.sv -----
// shared types, codes and the control program of the lcd number write sequencer
// depends on nothing; imported by cnws_bcd and the top level
`timescale 1ns / 1ps

package cnws_pkg;

    localparam int COLUMNS    = 16;
    localparam int MAX_DIGITS = 16;
    localparam int VAL_W      = 16;
    localparam int BCD_DIGITS = 5;
    localparam int BCD_W      = 4 * BCD_DIGITS;
    localparam int STEP_W     = 3;

    localparam logic [2:0] CMD_CHAR = 3'd0;
    localparam logic [2:0] CMD_UDEC = 3'd1;
    localparam logic [2:0] CMD_SDEC = 3'd2;
    localparam logic [2:0] CMD_HEX  = 3'd3;
    localparam logic [2:0] CMD_BIN  = 3'd4;

    localparam logic [7:0] LCD_SET_ADDR = 8'h80;
    localparam logic [6:0] LINE2_OFFSET = 7'h40;
    localparam logic [7:0] CHAR_ZERO    = 8'h30;
    localparam logic [7:0] CHAR_A       = 8'h41;
    localparam logic [7:0] CHAR_PLUS    = 8'h2B;
    localparam logic [7:0] CHAR_MINUS   = 8'h2D;

    typedef enum logic [2:0] {
        OP_ACCEPT = 3'd0,
        OP_CONV   = 3'd1,
        OP_ADDR   = 3'd2,
        OP_NOP    = 3'd3,
        OP_SIGN   = 3'd4,
        OP_DIGIT  = 3'd5,
        OP_CHAR   = 3'd6
    } op_t;

    typedef enum logic [1:0] {
        COND_NEVER      = 2'd0,
        COND_ALWAYS     = 2'd1,
        COND_CHAR       = 2'd2,
        COND_NOT_SIGNED = 2'd3
    } cond_t;

    typedef struct packed {
        op_t               op;
        cond_t             cond;
        logic [STEP_W-1:0] target;
    } ctrl_word_t;

    // control program: on completion an op jumps to target when its condition holds
    function automatic ctrl_word_t program_rom(input logic [STEP_W-1:0] step);
        ctrl_word_t cw;
        case (step)
            3'd0:    cw = '{OP_ACCEPT, COND_NEVER,      3'd0};
            3'd1:    cw = '{OP_CONV,   COND_NEVER,      3'd0};
            3'd2:    cw = '{OP_ADDR,   COND_NEVER,      3'd0};
            3'd3:    cw = '{OP_NOP,    COND_CHAR,       3'd7};
            3'd4:    cw = '{OP_NOP,    COND_NOT_SIGNED, 3'd6};
            3'd5:    cw = '{OP_SIGN,   COND_NEVER,      3'd0};
            3'd6:    cw = '{OP_DIGIT,  COND_ALWAYS,     3'd0};
            default: cw = '{OP_CHAR,   COND_ALWAYS,     3'd0};
        endcase
        return cw;
    endfunction

    function automatic logic [7:0] digit_char(input logic [3:0] d);
        logic [7:0] c;
        if (d < 4'd10) begin
            c = CHAR_ZERO + {4'd0, d};
        end else begin
            c = CHAR_A + {4'd0, d} - 8'd10;
        end
        return c;
    endfunction

endpackage

// ----- sv/cnws_bcd.sv -----
// binary to bcd converter, shift-and-add-three, one bit per cycle
// depends on cnws_pkg
`timescale 1ns / 1ps

module cnws_bcd
    import cnws_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [VAL_W-1:0] din,
    output logic [BCD_W-1:0] bcd,
    output logic             done
);

    localparam int CNT_W = $clog2(VAL_W + 1);

    logic [BCD_W-1:0] bcd_reg, bcd_next, bcd_adj;
    logic [VAL_W-1:0] sh_reg, sh_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    always_comb begin
        for (int i = 0; i < BCD_DIGITS; i++) begin
            if (bcd_reg[4*i +: 4] > 4'd4) begin
                bcd_adj[4*i +: 4] = bcd_reg[4*i +: 4] + 4'd3;
            end else begin
                bcd_adj[4*i +: 4] = bcd_reg[4*i +: 4];
            end
        end
    end

    always_comb begin
        bcd_next = bcd_reg;
        sh_next  = sh_reg;
        cnt_next = cnt_reg;
        if (start) begin
            bcd_next = '0;
            sh_next  = din;
            cnt_next = CNT_W'(VAL_W);
        end else if (cnt_reg != '0) begin
            bcd_next = {bcd_adj[BCD_W-2:0], sh_reg[VAL_W-1]};
            sh_next  = {sh_reg[VAL_W-2:0], 1'b0};
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
        end
        bcd_reg <= bcd_next;
        sh_reg  <= sh_next;
    end

    assign bcd  = bcd_reg;
    assign done = (cnt_reg == '0) && !start;

endmodule

// ----- sv/char_lcd_number_write_sequencer_unit.sv -----
// top level of the character lcd number write sequencer
// depends on cnws_pkg and cnws_bcd
`timescale 1ns / 1ps

// Each request beat (command, line, column, value, length) turns into a stream
// of display bus write beats: one set-address command (reg_select 0), then the
// data bytes (reg_select 1), with last on the final write. Column is clamped to
// 1..COLUMNS and length to sixteen; digits go most significant first with
// leading zeros kept. Control is a short microprogram of eight steps held in a
// read-only table in the package; a step counter walks it and conditional
// jumps select char, signed or plain number output. One request is handled at
// a time: s_ready is high only in the accept step. After the accept step the
// decimal modes wait in the convert step for the bit-serial bcd converter (one
// value bit per cycle) while other modes pass it at once; then come the address
// write, the branch steps, the sign for signed decimal, the digit writes and a
// closing step, which writes the character in char mode. The output register
// lets a finished write wait while the program moves on.

module char_lcd_number_write_sequencer_unit
    import cnws_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [2:0]  s_command,
    input  logic [1:0]  s_line,
    input  logic [4:0]  s_column,
    input  logic [15:0] s_value,
    input  logic [4:0]  s_length,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_reg_select,
    output logic [7:0]  m_bus_byte,
    output logic        m_last
);

    localparam int COL_W = $clog2(COLUMNS + 1) + 1;

    // program counter and request registers
    logic [STEP_W-1:0] step_reg, step_next;
    logic [2:0]        cmd_reg, cmd_next;
    logic [15:0]       mag_reg, mag_next;
    logic [4:0]        dcnt_reg, dcnt_next;
    logic [6:0]        addr_reg, addr_next;
    logic              neg_reg, neg_next;

    // output register
    logic              m_valid_reg, m_valid_next;
    logic              m_rs_reg, m_rs_next;
    logic [7:0]        m_byte_reg, m_byte_next;
    logic              m_last_reg, m_last_next;

    ctrl_word_t        cw;
    logic              cond_true, op_done, out_free, accept;
    logic              conv_start, conv_done;
    logic [BCD_W-1:0]  bcd;
    logic [COL_W-1:0]  col_ext, col_clamp;
    logic [6:0]        addr_in;
    logic [4:0]        len_clamp;
    logic [15:0]       mag_in;
    logic              neg_in;
    logic [3:0]        pos, digit;

    cnws_bcd u_bcd (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (conv_start),
        .din     (mag_in),
        .bcd     (bcd),
        .done    (conv_done)
    );

    assign cw       = program_rom(step_reg);
    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (cw.op == OP_ACCEPT);
    assign accept   = s_valid && s_ready;

    // request decode at accept
    always_comb begin
        col_ext = COL_W'(s_column);
        if (col_ext == '0) begin
            col_clamp = COL_W'(1);
        end else if (col_ext > COL_W'(COLUMNS)) begin
            col_clamp = COL_W'(COLUMNS);
        end else begin
            col_clamp = col_ext;
        end
        addr_in = 7'(col_clamp - 1'b1);
        if (s_line != 2'd1) begin
            addr_in = addr_in + LINE2_OFFSET;
        end
        len_clamp = (s_length > 5'(MAX_DIGITS)) ? 5'(MAX_DIGITS) : s_length;
        neg_in    = (s_command == CMD_SDEC) && s_value[15];
        mag_in    = neg_in ? (~s_value + 16'd1) : s_value;
    end

    assign conv_start = accept && (s_command == CMD_UDEC || s_command == CMD_SDEC);

    // digit at position dcnt-1, zero beyond the value's width
    assign pos = 4'(dcnt_reg - 5'd1);
    always_comb begin
        digit = 4'd0;
        case (cmd_reg) inside
            CMD_UDEC, CMD_SDEC: begin
                case (pos)
                    4'd0:    digit = bcd[3:0];
                    4'd1:    digit = bcd[7:4];
                    4'd2:    digit = bcd[11:8];
                    4'd3:    digit = bcd[15:12];
                    4'd4:    digit = bcd[19:16];
                    default: digit = 4'd0;
                endcase
            end
            CMD_HEX: begin
                if (pos < 4'd4) begin
                    digit = 4'(mag_reg >> {pos[1:0], 2'b00});
                end
            end
            CMD_BIN: digit = {3'd0, mag_reg[pos]};
            default: digit = 4'd0;
        endcase
    end

    always_comb begin
        unique case (cw.cond)
            COND_NEVER:      cond_true = 1'b0;
            COND_ALWAYS:     cond_true = 1'b1;
            COND_CHAR:       cond_true = (cmd_reg == CMD_CHAR);
            COND_NOT_SIGNED: cond_true = (cmd_reg != CMD_SDEC);
            default:         cond_true = 1'b0;
        endcase
    end

    // datapath driven by the current control word
    always_comb begin
        cmd_next     = cmd_reg;
        mag_next     = mag_reg;
        dcnt_next    = dcnt_reg;
        addr_next    = addr_reg;
        neg_next     = neg_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_rs_next    = m_rs_reg;
        m_byte_next  = m_byte_reg;
        m_last_next  = m_last_reg;
        op_done      = 1'b0;

        unique case (cw.op)
            OP_ACCEPT: begin
                if (s_valid) begin
                    cmd_next  = s_command;
                    mag_next  = mag_in;
                    addr_next = addr_in;
                    neg_next  = neg_in;
                    if (s_command == CMD_UDEC || s_command == CMD_SDEC ||
                        s_command == CMD_HEX || s_command == CMD_BIN) begin
                        dcnt_next = len_clamp;
                    end else begin
                        dcnt_next = 5'd0;
                    end
                    op_done = 1'b1;
                end
            end
            OP_CONV: begin
                op_done = conv_done;
            end
            OP_ADDR: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_rs_next    = 1'b0;
                    m_byte_next  = LCD_SET_ADDR | {1'b0, addr_reg};
                    m_last_next  = (dcnt_reg == 5'd0) && (cmd_reg != CMD_CHAR) &&
                                   (cmd_reg != CMD_SDEC);
                    op_done      = 1'b1;
                end
            end
            OP_NOP: begin
                op_done = 1'b1;
            end
            OP_SIGN: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_rs_next    = 1'b1;
                    m_byte_next  = neg_reg ? CHAR_MINUS : CHAR_PLUS;
                    m_last_next  = (dcnt_reg == 5'd0);
                    op_done      = 1'b1;
                end
            end
            OP_DIGIT: begin
                if (dcnt_reg == 5'd0) begin
                    op_done = 1'b1;
                end else if (out_free) begin
                    m_valid_next = 1'b1;
                    m_rs_next    = 1'b1;
                    m_byte_next  = digit_char(digit);
                    m_last_next  = (dcnt_reg == 5'd1);
                    dcnt_next    = dcnt_reg - 5'd1;
                end
            end
            OP_CHAR: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_rs_next    = 1'b1;
                    m_byte_next  = mag_reg[7:0];
                    m_last_next  = 1'b1;
                    op_done      = 1'b1;
                end
            end
            default: op_done = 1'b0;
        endcase

        if (op_done) begin
            step_next = cond_true ? cw.target : step_reg + 1'b1;
        end else begin
            step_next = step_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            step_reg    <= step_next;
            m_valid_reg <= m_valid_next;
        end
        cmd_reg    <= cmd_next;
        mag_reg    <= mag_next;
        dcnt_reg   <= dcnt_next;
        addr_reg   <= addr_next;
        neg_reg    <= neg_next;
        m_rs_reg   <= m_rs_next;
        m_byte_reg <= m_byte_next;
        m_last_reg <= m_last_next;
    end

    assign m_valid      = m_valid_reg;
    assign m_reg_select = m_rs_reg;
    assign m_bus_byte   = m_byte_reg;
    assign m_last       = m_last_reg;

endmodule
